### rtl/rbsi_pkg.sv
`default_nettype none

package rbsi_pkg;

   // Saturation bounds of the signed 32-bit result range.
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Face codes reported on a hit.
   localparam logic [2:0] FACE_NEG_X = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_Y = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Z = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;

   // One request beat: ray and box.
   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_time;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [2:0]         face;
   } rsp_type;

   // What one axis lane hands to the merging stage.
   typedef struct packed {
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
      logic               active;
      logic               miss;
      logic signed [31:0] start_pos;
      logic signed [31:0] dir;
   } lane_type;

endpackage

`default_nettype wire

### rtl/ray_box_slab_intersect.sv
`default_nettype none

// Ray versus axis-aligned box test by the slab method, fixed point with
// COORD_FRAC_BITS fraction bits. A fully pipelined block: busy stays low, a
// beat is taken on every cycle that start is high, and each beat gives one
// response beat. That beat is marked by rsp_strobe for one cycle. Most of
// the pipeline is in the slab-distance dividers. They resolve one quotient
// bit per pipeline stage over COORD_FRAC_BITS + 33 stages, with an operand
// register ahead of those stages and a result register behind them. The
// input register, which takes the beat, and five merge stages make up the
// rest. Responses come out in request order and cannot be held off, so the
// receiver must take every strobed beat.
module ray_box_slab_intersect #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rbsi_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output rbsi_pkg::rsp_type      rsp_data
);

   localparam int LAT = COORD_FRAC_BITS + 41;

   rbsi_pkg::req_type  req_ff;
   logic [LAT-1:0]     vld_ff;
   logic [LAT-1:0]     vld_in;
   logic               accept;
   rbsi_pkg::lane_type lane_res [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Valid tracking alongside the data pipeline.
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   rbsi_lane #(.FRAC_BITS(COORD_FRAC_BITS)) u_lane_x (
      .clock     (clock),
      .start_pos (req_ff.start_x),
      .dir       (req_ff.dir_x),
      .box_min   (req_ff.box_min_x),
      .box_max   (req_ff.box_max_x),
      .res       (lane_res[0])
   );

   rbsi_lane #(.FRAC_BITS(COORD_FRAC_BITS)) u_lane_y (
      .clock     (clock),
      .start_pos (req_ff.start_y),
      .dir       (req_ff.dir_y),
      .box_min   (req_ff.box_min_y),
      .box_max   (req_ff.box_max_y),
      .res       (lane_res[1])
   );

   rbsi_lane #(.FRAC_BITS(COORD_FRAC_BITS)) u_lane_z (
      .clock     (clock),
      .start_pos (req_ff.start_z),
      .dir       (req_ff.dir_z),
      .box_min   (req_ff.box_min_z),
      .box_max   (req_ff.box_max_z),
      .res       (lane_res[2])
   );

   rbsi_merge #(.FRAC_BITS(COORD_FRAC_BITS)) u_merge (
      .clock (clock),
      .lane  (lane_res),
      .rsp   (rsp_data)
   );

   assign rsp_strobe = vld_ff[LAT-1];

`ifndef SYNTHESIS
   // A response beat always traces back to an earlier request beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("response beat without a matching request beat");

   // A miss carries a zero distance and a zero face code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |->
         (rsp_data.hit_time == 0) && (rsp_data.face == rbsi_pkg::FACE_NEG_X))
      else $error("miss response carries nonzero fields");

   // A hit names one of the six faces.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |->
         (rsp_data.face <= rbsi_pkg::FACE_POS_Z))
      else $error("hit response with invalid face");
`endif

endmodule

`default_nettype wire

### rtl/rbsi_div.sv
`default_nettype none

// Pipelined restoring divider: ((diff << FRAC_BITS) / den), truncated toward
// zero and saturated to 32 bits. One quotient bit is resolved per stage.
module rbsi_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic signed [32:0] num_diff,
   input  wire logic signed [31:0] den,
   output logic signed [31:0]      quot
);

   localparam int NW = 33 + FRAC_BITS;
   localparam int RW = 32;

   logic [NW-1:0] n_ff   [NW];
   logic [RW-1:0] r_ff   [NW];
   logic [RW-1:0] d_ff   [NW];
   logic [NW-1:0] q_ff   [NW+1];
   logic          neg_ff [NW+1];
   logic signed [31:0] quot_ff;

   logic [32:0] nmag;
   logic [31:0] dmag;

   // Operand magnitudes and result sign.
   always_comb begin
      nmag = num_diff[32] ? 33'(-num_diff) : 33'(num_diff);
      dmag = den[31] ? 32'(-den) : 32'(den);
   end

   always_ff @(posedge clock) begin
      n_ff[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      r_ff[0]   <= '0;
      d_ff[0]   <= dmag;
      q_ff[0]   <= '0;
      neg_ff[0] <= num_diff[32] ^ den[31];
   end

   // One trial subtraction per stage.
   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [RW:0] trial;
      logic        ge;

      always_comb begin
         trial = {r_ff[s], n_ff[s][NW-1]};
         ge    = trial >= {1'b0, d_ff[s]};
      end

      always_ff @(posedge clock) begin
         q_ff[s+1]   <= {q_ff[s][NW-2:0], ge};
         neg_ff[s+1] <= neg_ff[s];
      end

      if (s < NW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            r_ff[s+1] <= ge ? RW'(trial - {1'b0, d_ff[s]}) : trial[RW-1:0];
            n_ff[s+1] <= n_ff[s] << 1;
            d_ff[s+1] <= d_ff[s];
         end
      end
   end

   // Apply the sign and saturate the magnitude.
   always_ff @(posedge clock) begin
      if (!neg_ff[NW]) begin
         if (q_ff[NW][NW-1:31] != '0) begin
            quot_ff <= rbsi_pkg::S32_MAX;
         end else begin
            quot_ff <= q_ff[NW][31:0];
         end
      end else begin
         if ((q_ff[NW][NW-1:32] != '0) || (q_ff[NW][31] && (q_ff[NW][30:0] != '0))) begin
            quot_ff <= rbsi_pkg::S32_MIN;
         end else begin
            quot_ff <= -q_ff[NW][31:0];
         end
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

### rtl/rbsi_lane.sv
`default_nettype none

// One axis: distances to both slab planes, plus the zero-direction test.
module rbsi_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic signed [31:0] start_pos,
   input  wire logic signed [31:0] dir,
   input  wire logic signed [31:0] box_min,
   input  wire logic signed [31:0] box_max,
   output rbsi_pkg::lane_type      res
);

   localparam int DL = 35 + FRAC_BITS;

   logic signed [32:0] diff_min;
   logic signed [32:0] diff_max;
   logic signed [31:0] t_min;
   logic signed [31:0] t_max;
   logic [65:0]        side_in;
   logic [65:0]        side_ff [DL];

   // Plane offsets from the origin, one bit wider than the coordinates.
   always_comb begin
      diff_min = {box_min[31], box_min} - {start_pos[31], start_pos};
      diff_max = {box_max[31], box_max} - {start_pos[31], start_pos};
      side_in  = {start_pos, dir, (dir == '0),
                  ((start_pos >= box_min) && (start_pos <= box_max))};
   end

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
      .clock    (clock),
      .num_diff (diff_min),
      .den      (dir),
      .quot     (t_min)
   );

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
      .clock    (clock),
      .num_diff (diff_max),
      .den      (dir),
      .quot     (t_max)
   );

   // Origin, direction and flags ride alongside the dividers.
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < DL; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   always_comb begin
      res.t_min     = t_min;
      res.t_max     = t_max;
      res.start_pos = side_ff[DL-1][65:34];
      res.dir       = side_ff[DL-1][33:2];
      res.active    = !side_ff[DL-1][1];
      res.miss      = side_ff[DL-1][1] && !side_ff[DL-1][0];
   end

endmodule

`default_nettype wire

### rtl/rbsi_merge.sv
`default_nettype none

// Combines the three lanes: entry and exit, miss test, face, hit point.
// Five register stages, the last one being the response register.
module rbsi_merge #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire rbsi_pkg::lane_type lane [3],
   output rbsi_pkg::rsp_type       rsp
);

   rbsi_pkg::lane_type l1_ff [3];
   rbsi_pkg::lane_type l2_ff [3];
   logic signed [31:0] lo_in [3];
   logic signed [31:0] hi_in [3];
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];
   logic signed [31:0] enter_in;
   logic signed [31:0] exit_in;
   logic signed [31:0] enter_ff;
   logic signed [31:0] exit_ff;
   logic               miss_in;
   logic [2:0]         face_in;
   logic               miss3_ff;
   logic [2:0]         face3_ff;
   logic signed [31:0] enter3_ff;
   logic signed [31:0] start3_ff [3];
   logic signed [31:0] dir3_ff [3];
   logic               miss4_ff;
   logic [2:0]         face4_ff;
   logic signed [31:0] enter4_ff;
   logic signed [31:0] start4_ff [3];
   logic signed [63:0] prod_ff [3];
   logic signed [31:0] point_in [3];
   rbsi_pkg::rsp_type  rsp_ff;

   // Near and far distance per axis; an idle axis constrains nothing.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (!lane[a].active) begin
            lo_in[a] = rbsi_pkg::S32_MIN;
            hi_in[a] = rbsi_pkg::S32_MAX;
         end else if (lane[a].t_min < lane[a].t_max) begin
            lo_in[a] = lane[a].t_min;
            hi_in[a] = lane[a].t_max;
         end else begin
            lo_in[a] = lane[a].t_max;
            hi_in[a] = lane[a].t_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         l1_ff[a] <= lane[a];
         lo_ff[a] <= lo_in[a];
         hi_ff[a] <= hi_in[a];
      end
   end

   // Entry is the greatest near distance, exit the least far distance.
   always_comb begin
      enter_in = lo_ff[0];
      if (lo_ff[1] > enter_in) begin
         enter_in = lo_ff[1];
      end
      if (lo_ff[2] > enter_in) begin
         enter_in = lo_ff[2];
      end
      exit_in = hi_ff[0];
      if (hi_ff[1] < exit_in) begin
         exit_in = hi_ff[1];
      end
      if (hi_ff[2] < exit_in) begin
         exit_in = hi_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      l2_ff    <= l1_ff;
      enter_ff <= enter_in;
      exit_ff  <= exit_in;
   end

   // Miss test and entered face; later faces win ties.
   always_comb begin
      miss_in = l2_ff[0].miss || l2_ff[1].miss || l2_ff[2].miss ||
                !(l2_ff[0].active || l2_ff[1].active || l2_ff[2].active) ||
                (exit_ff < 0) || (enter_ff > exit_ff);
      face_in = rbsi_pkg::FACE_NEG_X;
      if (l2_ff[0].active && (l2_ff[0].t_min == enter_ff)) begin
         face_in = rbsi_pkg::FACE_NEG_X;
      end
      if (l2_ff[0].active && (l2_ff[0].t_max == enter_ff)) begin
         face_in = rbsi_pkg::FACE_POS_X;
      end
      if (l2_ff[1].active && (l2_ff[1].t_min == enter_ff)) begin
         face_in = rbsi_pkg::FACE_NEG_Y;
      end
      if (l2_ff[1].active && (l2_ff[1].t_max == enter_ff)) begin
         face_in = rbsi_pkg::FACE_POS_Y;
      end
      if (l2_ff[2].active && (l2_ff[2].t_min == enter_ff)) begin
         face_in = rbsi_pkg::FACE_NEG_Z;
      end
      if (l2_ff[2].active && (l2_ff[2].t_max == enter_ff)) begin
         face_in = rbsi_pkg::FACE_POS_Z;
      end
   end

   always_ff @(posedge clock) begin
      miss3_ff  <= miss_in;
      face3_ff  <= face_in;
      enter3_ff <= enter_ff;
      for (int a = 0; a < 3; a++) begin
         start3_ff[a] <= l2_ff[a].start_pos;
         dir3_ff[a]   <= l2_ff[a].dir;
      end
   end

   // Direction times entry distance, one multiplier per axis.
   always_ff @(posedge clock) begin
      miss4_ff  <= miss3_ff;
      face4_ff  <= face3_ff;
      enter4_ff <= enter3_ff;
      for (int a = 0; a < 3; a++) begin
         start4_ff[a] <= start3_ff[a];
         prod_ff[a]   <= dir3_ff[a] * enter3_ff;
      end
   end

   // Floor-scale the product, add the origin and saturate.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [63:0] shifted;
         logic signed [64:0] sum;
         shifted = prod_ff[a] >>> FRAC_BITS;
         sum = {{33{start4_ff[a][31]}}, start4_ff[a]} + {shifted[63], shifted};
         if (sum > 65'sd2147483647) begin
            point_in[a] = rbsi_pkg::S32_MAX;
         end else if (sum < -65'sd2147483648) begin
            point_in[a] = rbsi_pkg::S32_MIN;
         end else begin
            point_in[a] = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (miss4_ff) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff.hit      <= 1'b1;
         rsp_ff.hit_time <= enter4_ff;
         rsp_ff.point_x  <= point_in[0];
         rsp_ff.point_y  <= point_in[1];
         rsp_ff.point_z  <= point_in[2];
         rsp_ff.face     <= face4_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
